FILE: rtl/core/bcmpg_pkg.sv
// shared types and constants of the band column minimum peak gauge
`timescale 1ns / 1ps

package bcmpg_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int DIM_W       = 11;
  localparam int POS_W       = 10;
  localparam int VAL_W       = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int PROD_W      = 36;
  localparam int DIV_STEPS   = PROD_W;
  localparam int DCNT_W      = $clog2(DIV_STEPS);
  localparam int ADDR_W      = 5;

  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_SCAN_ROW      = 3'd2;
  localparam logic [2:0] REG_BAND_HALF     = 3'd3;
  localparam logic [2:0] REG_FIRST_COLUMN  = 3'd4;
  localparam logic [2:0] REG_FIRST_VALUE   = 3'd5;
  localparam logic [2:0] REG_SECOND_COLUMN = 3'd6;
  localparam logic [2:0] REG_SECOND_VALUE  = 3'd7;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [DIM_W-1:0] needle_column;
    logic [7:0]              needle_level;
    logic signed [VAL_W-1:0] reading;
    logic                    no_needle;
    logic                    calibration_error;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [POS_W-1:0] scan_row;
    logic [POS_W-1:0] band_half;
  } geom_t;

  typedef struct packed {
    logic [POS_W-1:0]        first_column;
    logic signed [VAL_W-1:0] first_value;
    logic [POS_W-1:0]        second_column;
    logic signed [VAL_W-1:0] second_value;
  } cal_t;

  typedef struct packed {
    logic [COL_W-1:0] addr;
    logic [7:0]       pixel;
    logic             examine;
    logic             band_first;
    logic             band_last;
    logic             clear_best;
    logic             frame_last;
    logic             band_empty;
  } pix_op_t;

  typedef struct packed {
    logic                    start;
    logic signed [DIM_W-1:0] column;
    logic [7:0]              level;
  } needle_req_t;

endpackage

FILE: rtl/core/bcmpg_front.sv
// front end: raster position counters and band classification of each pixel
`timescale 1ns / 1ps

module bcmpg_front import bcmpg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  geom_t    geom,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     push,
  output pix_op_t  push_op
);

  localparam logic [DIM_W-1:0] MAX_W_VAL = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_VAL = DIM_W'(MAX_HEIGHT);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] w_eff, h_eff, hi_sum, hi, x_inc, y_inc;
  logic [POS_W-1:0] lo;
  logic [COL_W-1:0] x;
  logic [ROW_W-1:0] y;
  logic             band_empty, row_end, frame_end;

  always_comb begin
    if (geom.frame_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (geom.frame_width > MAX_W_VAL) begin
      w_eff = MAX_W_VAL;
    end else begin
      w_eff = geom.frame_width;
    end
    if (geom.frame_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (geom.frame_height > MAX_H_VAL) begin
      h_eff = MAX_H_VAL;
    end else begin
      h_eff = geom.frame_height;
    end

    lo = (geom.scan_row >= geom.band_half) ? geom.scan_row - geom.band_half : '0;
    hi_sum = DIM_W'(geom.scan_row) + DIM_W'(geom.band_half);
    hi = (hi_sum >= h_eff) ? h_eff - DIM_W'(1) : hi_sum;
    band_empty = hi <= DIM_W'(lo);

    x = in_data.frame_start ? '0 : col_r;
    y = in_data.frame_start ? '0 : row_r;
    x_inc = DIM_W'(x) + DIM_W'(1);
    y_inc = DIM_W'(y) + DIM_W'(1);
    row_end = x_inc >= w_eff;
    frame_end = row_end && (y_inc >= h_eff);

    push_op.addr       = x;
    push_op.pixel      = in_data.pixel;
    push_op.examine    = !band_empty && (DIM_W'(y) >= DIM_W'(lo)) && (DIM_W'(y) < hi);
    push_op.band_first = DIM_W'(y) == DIM_W'(lo);
    push_op.band_last  = y_inc == hi;
    push_op.clear_best = in_data.frame_start;
    push_op.frame_last = frame_end;
    push_op.band_empty = band_empty;

    in_ready = !q_full;
    push = in_valid && in_ready;

    col_nxt = col_r;
    row_nxt = row_r;
    if (push) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : ROW_W'(y_inc);
      end else begin
        col_nxt = COL_W'(x_inc);
        row_nxt = y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

FILE: rtl/core/bcmpg_queue.sv
// short request queue between front end and back end
`timescale 1ns / 1ps

module bcmpg_queue import bcmpg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  pix_op_t push_op,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output pix_op_t head_op
);

  pix_op_t           entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full       = count_r == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_op    = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

FILE: rtl/core/bcmpg_back.sv
// back end: column minimum memory and running best column
`timescale 1ns / 1ps

module bcmpg_back import bcmpg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  pix_op_t     q_op,
  output logic        pop,
  input  logic        gauge_busy,
  output needle_req_t needle_req
);

  localparam logic signed [DIM_W-1:0] NO_COLUMN = -DIM_W'(1);

  logic [7:0] colmin_mem [MAX_WIDTH];

  logic                    b_valid_r, b_valid_nxt;
  pix_op_t                 b_op_r;
  logic [7:0]              rd_data_r;
  logic                    fwd_hit_r, fwd_hit_nxt;
  logic [7:0]              fwd_data_r;
  logic [7:0]              best_level_r, best_level_nxt;
  logic signed [DIM_W-1:0] best_column_r, best_column_nxt;
  logic [7:0]              prev, m, base_lvl, upd_lvl;
  logic signed [DIM_W-1:0] base_col, upd_col;
  logic                    wr_en;

  always_comb begin
    prev = fwd_hit_r ? fwd_data_r : rd_data_r;
    m = (!b_op_r.band_first && (prev < b_op_r.pixel)) ? prev : b_op_r.pixel;

    base_lvl = b_op_r.clear_best ? 8'd0 : best_level_r;
    base_col = b_op_r.clear_best ? NO_COLUMN : best_column_r;
    upd_lvl = base_lvl;
    upd_col = base_col;
    if (b_op_r.examine && b_op_r.band_last && (m > base_lvl)) begin
      upd_lvl = m;
      upd_col = $signed(DIM_W'(b_op_r.addr));
    end

    best_level_nxt  = best_level_r;
    best_column_nxt = best_column_r;
    if (b_valid_r) begin
      if (b_op_r.frame_last) begin
        best_level_nxt  = 8'd0;
        best_column_nxt = NO_COLUMN;
      end else begin
        best_level_nxt  = upd_lvl;
        best_column_nxt = upd_col;
      end
    end

    needle_req.start  = b_valid_r && b_op_r.frame_last;
    needle_req.column = b_op_r.band_empty ? '0 : upd_col;
    needle_req.level  = b_op_r.band_empty ? 8'hFF : upd_lvl;

    pop = q_valid && !(q_op.frame_last &&
                       (gauge_busy || (b_valid_r && b_op_r.frame_last)));
    b_valid_nxt = pop;
    wr_en = b_valid_r && b_op_r.examine;
    fwd_hit_nxt = wr_en && pop && (q_op.addr == b_op_r.addr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r     <= 1'b0;
      fwd_hit_r     <= 1'b0;
      best_level_r  <= 8'd0;
      best_column_r <= NO_COLUMN;
    end else begin
      b_valid_r     <= b_valid_nxt;
      fwd_hit_r     <= fwd_hit_nxt;
      best_level_r  <= best_level_nxt;
      best_column_r <= best_column_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      colmin_mem[b_op_r.addr] <= m;
    end
    if (pop) begin
      rd_data_r <= colmin_mem[q_op.addr];
      b_op_r    <= q_op;
    end
    fwd_data_r <= m;
  end

endmodule

FILE: rtl/core/bcmpg_gauge.sv
// gauge unit: interpolation product, bit-serial divide, saturation, result register
`timescale 1ns / 1ps

module bcmpg_gauge import bcmpg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cal_t        cal,
  input  needle_req_t needle_req,
  output logic        busy,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int DV_W  = VAL_W + 1;
  localparam int SUM_W = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (VAL_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(1 << (VAL_W - 1));

  typedef enum logic [2:0] {G_IDLE, G_MUL, G_DIV, G_SUM, G_OUT} g_state_t;

  g_state_t                state_r, state_nxt;
  logic signed [DIM_W-1:0] col_r, col_nxt, diff_r, diff_nxt, dc_r, dc_nxt;
  logic [7:0]              lvl_r, lvl_nxt;
  logic signed [DV_W-1:0]  dv_r, dv_nxt;
  logic [PROD_W-1:0]       quo_r, quo_nxt;
  logic [POS_W-1:0]        rem_r, rem_nxt, div_r, div_nxt;
  logic                    neg_r, neg_nxt;
  logic [DCNT_W-1:0]       cnt_r, cnt_nxt;
  out_item_t               out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic signed [PROD_W-1:0] prod;
  logic [POS_W:0]           trial;
  logic                     ge;
  logic signed [SUM_W-1:0]  q_mag, q_sgn, sum, sat;
  logic                     cal_err;

  assign busy      = state_r != G_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    lvl_nxt       = lvl_r;
    diff_nxt      = diff_r;
    dc_nxt        = dc_r;
    dv_nxt        = dv_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    prod  = PROD_W'(dv_r) * PROD_W'(diff_r);
    trial = {rem_r, quo_r[PROD_W-1]};
    ge    = trial >= {1'b0, div_r};
    q_mag = $signed({2'b00, quo_r});
    q_sgn = neg_r ? -q_mag : q_mag;
    sum   = SUM_W'(cal.first_value) + q_sgn;
    if (sum > SAT_HI) begin
      sat = SAT_HI;
    end else if (sum < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = sum;
    end
    cal_err = cal.first_column == cal.second_column;

    unique case (state_r)
      G_IDLE: begin
        if (needle_req.start) begin
          col_nxt   = needle_req.column;
          lvl_nxt   = needle_req.level;
          diff_nxt  = needle_req.column - $signed({1'b0, cal.first_column});
          dc_nxt    = $signed({1'b0, cal.second_column}) - $signed({1'b0, cal.first_column});
          dv_nxt    = DV_W'(cal.second_value) - DV_W'(cal.first_value);
          state_nxt = G_MUL;
        end
      end
      G_MUL: begin
        quo_nxt   = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        neg_nxt   = prod[PROD_W-1] ^ dc_r[DIM_W-1];
        div_nxt   = dc_r[DIM_W-1] ? POS_W'(-dc_r) : dc_r[POS_W-1:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = G_DIV;
      end
      G_DIV: begin
        rem_nxt = ge ? POS_W'(trial - {1'b0, div_r}) : trial[POS_W-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], ge};
        cnt_nxt = cnt_r + DCNT_W'(1);
        if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = G_SUM;
        end
      end
      G_SUM: begin
        out_nxt.needle_column     = col_r;
        out_nxt.needle_level      = lvl_r;
        out_nxt.reading           = cal_err ? '0 : sat[VAL_W-1:0];
        out_nxt.no_needle         = col_r == -DIM_W'(1);
        out_nxt.calibration_error = cal_err;
        out_valid_nxt             = 1'b1;
        state_nxt                 = G_OUT;
      end
      G_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = G_IDLE;
        end
      end
      default: begin
        state_nxt = G_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= G_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r  <= col_nxt;
    lvl_r  <= lvl_nxt;
    diff_r <= diff_nxt;
    dc_r   <= dc_nxt;
    dv_r   <= dv_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    out_r  <= out_nxt;
  end

endmodule

FILE: rtl/core/band_column_min_peak_gauge.sv
// top level: configuration registers and the front, queue, back and gauge parts
//
// pixels enter on in_valid/in_ready in raster order, one request per cycle
// while in_ready is high; in_data.frame_start marks row 0, column 0 of a frame.
// for each column the block keeps the minimum over the band of rows around
// scan_row and tracks the first column with the greatest band minimum.
// on the last pixel of a frame one result leaves on out_valid/out_ready:
// needle column and level, the gauge reading interpolated between the two
// calibration points (signed q15.8, saturated) and two status flags.
// throughput is one pixel per cycle unless in_ready is low; a frame result
// passes the queue, the back end and the gauge's 36-step bit-serial divider.
// the result waits in an output register while pixels of the next frame keep
// flowing; only the last pixel of the next frame waits for the gauge unit,
// and a full four-entry queue then drops in_ready.
// reset clears counters, best column, queue and result valid and loads the
// default register values; the column minimum memory is not cleared.
// registers are written over apb at byte address 4 * index; the user must
// write only while the block is idle (not enforced); pready is always high.
`timescale 1ns / 1ps

module band_column_min_peak_gauge import bcmpg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  geom_t       geom_r;
  cal_t        cal_r;
  logic        wr_en;
  logic [2:0]  reg_idx;
  logic        q_full, push, pop, q_valid, gauge_busy;
  pix_op_t     push_op, q_op;
  needle_req_t needle_req;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.frame_width  <= DIM_W'(640);
      geom_r.frame_height <= DIM_W'(480);
      geom_r.scan_row     <= POS_W'(172);
      geom_r.band_half    <= POS_W'(10);
      cal_r.first_column  <= POS_W'(100);
      cal_r.first_value   <= VAL_W'(25600);
      cal_r.second_column <= POS_W'(400);
      cal_r.second_value  <= VAL_W'(102400);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:   geom_r.frame_width  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT:  geom_r.frame_height <= pwdata[DIM_W-1:0];
        REG_SCAN_ROW:      geom_r.scan_row     <= pwdata[POS_W-1:0];
        REG_BAND_HALF:     geom_r.band_half    <= pwdata[POS_W-1:0];
        REG_FIRST_COLUMN:  cal_r.first_column  <= pwdata[POS_W-1:0];
        REG_FIRST_VALUE:   cal_r.first_value   <= $signed(pwdata[VAL_W-1:0]);
        REG_SECOND_COLUMN: cal_r.second_column <= pwdata[POS_W-1:0];
        REG_SECOND_VALUE:  cal_r.second_value  <= $signed(pwdata[VAL_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:   prdata = 32'(geom_r.frame_width);
      REG_FRAME_HEIGHT:  prdata = 32'(geom_r.frame_height);
      REG_SCAN_ROW:      prdata = 32'(geom_r.scan_row);
      REG_BAND_HALF:     prdata = 32'(geom_r.band_half);
      REG_FIRST_COLUMN:  prdata = 32'(cal_r.first_column);
      REG_FIRST_VALUE:   prdata = 32'(cal_r.first_value);
      REG_SECOND_COLUMN: prdata = 32'(cal_r.second_column);
      REG_SECOND_VALUE:  prdata = 32'(cal_r.second_value);
      default:           prdata = '0;
    endcase
  end

  bcmpg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .geom     (geom_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  bcmpg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_op    (q_op)
  );

  bcmpg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .pop        (pop),
    .gauge_busy (gauge_busy),
    .needle_req (needle_req)
  );

  bcmpg_gauge u_gauge (
    .clk        (clk),
    .rst_n      (rst_n),
    .cal        (cal_r),
    .needle_req (needle_req),
    .busy       (gauge_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

FILE: verif/tb_band_column_min_peak_gauge.sv
// testbench for the band column minimum peak gauge: directed table, random frames, self-checking
`timescale 1ns / 1ps

module tb_band_column_min_peak_gauge;
  import bcmpg_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 400;

  typedef enum {STEP_REG, STEP_PIXEL} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [2:0]  reg_index;
    logic [31:0] reg_value;
    in_item_t    px;
    bit          typed;
    out_item_t   want;
  } step_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // register copy, reset values
  logic [10:0]        cfg_width = 11'd640;
  logic [10:0]        cfg_height = 11'd480;
  logic [9:0]         cfg_scan = 10'd172;
  logic [9:0]         cfg_half = 10'd10;
  logic [9:0]         cfg_col1 = 10'd100;
  logic signed [23:0] cfg_val1 = 24'sd25600;
  logic [9:0]         cfg_col2 = 10'd400;
  logic signed [23:0] cfg_val2 = 24'sd102400;

  // column minima and needle tracking
  bit [7:0]   col_min [MAX_WIDTH];
  int         col_pos = 0;
  int         row_pos = 0;
  logic [7:0] top_level = 8'd0;
  int         top_column = -1;

  out_item_t pending_readings [$];
  int        bad_results = 0;
  int        pixels_sent = 0;
  int        burst_left = 0;
  bit        hold_out = 1'b0;
  step_t     plan [$];

  band_column_min_peak_gauge dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic int clamp_dim(input int v, input int top);
    if (v < 1) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic logic signed [23:0] gauge_reading(input int pos);
    longint span_c, span_v, r;
    span_c = longint'(cfg_col2) - longint'(cfg_col1);
    span_v = longint'(cfg_val2) - longint'(cfg_val1);
    r = longint'(cfg_val1) + span_v * (longint'(pos) - longint'(cfg_col1)) / span_c;
    if (r > 64'sd8388607) r = 64'sd8388607;
    if (r < -64'sd8388608) r = -64'sd8388608;
    return r[23:0];
  endfunction

  // advances the raster position; returns 1 with the frame reading on the last pixel
  function automatic bit track_pixel(input in_item_t it, output out_item_t res);
    int         w, h, lo, hi, x, y, col;
    logic [7:0] m, lvl;
    bit         empty, last, cal_err;
    w = clamp_dim(cfg_width, MAX_WIDTH);
    h = clamp_dim(cfg_height, MAX_HEIGHT);
    res = '0;
    if (it.frame_start) begin
      col_pos = 0;
      row_pos = 0;
      top_level = 8'd0;
      top_column = -1;
    end
    lo = int'(cfg_scan) - int'(cfg_half);
    if (lo < 0) lo = 0;
    hi = int'(cfg_scan) + int'(cfg_half);
    if (hi >= h) hi = h - 1;
    empty = hi <= lo;
    x = col_pos;
    y = row_pos;
    if (!empty && x < MAX_WIDTH && y >= lo && y < hi) begin
      m = it.pixel;
      if (y > lo && col_min[x] < m) m = col_min[x];
      col_min[x] = m;
      if (y == hi - 1 && m > top_level) begin
        top_level = m;
        top_column = x;
      end
    end
    last = (x + 1 >= w) && (y + 1 >= h);
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
    if (!last) return 1'b0;
    col = top_column;
    lvl = top_level;
    cal_err = cfg_col1 == cfg_col2;
    if (empty) begin
      col = 0;
      lvl = 8'd255;
    end
    res.needle_column = col[10:0];
    res.needle_level = lvl;
    res.reading = cal_err ? '0 : gauge_reading(col);
    res.no_needle = col == -1;
    res.calibration_error = cal_err;
    top_level = 8'd0;
    top_column = -1;
    return 1'b1;
  endfunction

  function automatic step_t reg_step(input logic [2:0] idx, input logic [31:0] value);
    step_t s;
    s = '{kind: STEP_REG, default: '0};
    s.kind = STEP_REG;
    s.reg_index = idx;
    s.reg_value = value;
    return s;
  endfunction

  function automatic step_t pixel_step(input logic [7:0] pix, input bit fs);
    step_t s;
    s = '{kind: STEP_PIXEL, default: '0};
    s.kind = STEP_PIXEL;
    s.px.pixel = pix;
    s.px.frame_start = fs;
    return s;
  endfunction

  function automatic step_t pixel_want(input logic [7:0] pix, input bit fs, input int col,
                                       input int lvl, input int rd, input bit nn, input bit ce);
    step_t s;
    s = pixel_step(pix, fs);
    s.typed = 1'b1;
    s.want.needle_column = col[10:0];
    s.want.needle_level = lvl[7:0];
    s.want.reading = rd[23:0];
    s.want.no_needle = nn;
    s.want.calibration_error = ce;
    return s;
  endfunction

  function automatic logic [7:0] pick_pixel(input int style);
    case (style)
      0: return 8'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      2: return ($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
      default: return 8'($urandom_range(250, 255));
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h0080_0000;
      1: return 32'h007f_ffff;
      default: return $urandom & 32'h00ff_ffff;
    endcase
  endfunction

  task automatic send_pixel(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t res;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
    if (track_pixel(it, res)) pending_readings.push_back(typed ? want : res);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // trailing pixels of a partial frame may still be in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:   cfg_width = value[10:0];
      REG_FRAME_HEIGHT:  cfg_height = value[10:0];
      REG_SCAN_ROW:      cfg_scan = value[9:0];
      REG_BAND_HALF:     cfg_half = value[9:0];
      REG_FIRST_COLUMN:  cfg_col1 = value[9:0];
      REG_FIRST_VALUE:   cfg_val1 = value[23:0];
      REG_SECOND_COLUMN: cfg_col2 = value[9:0];
      REG_SECOND_VALUE:  cfg_val2 = value[23:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_phase(input logic [31:0] w, input logic [31:0] h,
                               input logic [31:0] scan, input logic [31:0] half,
                               input logic [31:0] c1, input logic [31:0] v1,
                               input logic [31:0] c2, input logic [31:0] v2);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_SCAN_ROW, scan);
    write_reg(REG_BAND_HALF, half);
    write_reg(REG_FIRST_COLUMN, c1);
    write_reg(REG_FIRST_VALUE, v1);
    write_reg(REG_SECOND_COLUMN, c2);
    write_reg(REG_SECOND_VALUE, v2);
  endtask

  // carry: first pixel keeps the counters left by the previous phase
  task automatic stream_frames(input int frames, input bit carry, input bit noisy);
    int        fsz, len, style;
    in_item_t  it;
    out_item_t none;
    none = '0;
    fsz = clamp_dim(cfg_width, MAX_WIDTH) * clamp_dim(cfg_height, MAX_HEIGHT);
    for (int f = 0; f < frames; f++) begin
      len = fsz;
      if (noisy && $urandom_range(0, 9) == 0) len = $urandom_range(1, fsz);
      style = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        it.pixel = pick_pixel(style);
        if (i == 0) begin
          it.frame_start = (f == 0) ? !carry : 1'($urandom_range(0, 1));
        end else begin
          it.frame_start = noisy && ($urandom_range(0, 199) == 0);
        end
        send_pixel(it, 1'b0, none);
        pace();
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected result: needle_column %0d", out_data.needle_column);
        bad_results++;
      end else begin
        want = pending_readings.pop_front();
        if (out_data.needle_column !== want.needle_column) begin
          $error("needle_column: expected %0d, got %0d", want.needle_column,
                 out_data.needle_column);
          bad_results++;
        end
        if (out_data.needle_level !== want.needle_level) begin
          $error("needle_level: expected %0d, got %0d", want.needle_level,
                 out_data.needle_level);
          bad_results++;
        end
        if (out_data.reading !== want.reading) begin
          $error("reading: expected %0d, got %0d", want.reading, out_data.reading);
          bad_results++;
        end
        if (out_data.no_needle !== want.no_needle) begin
          $error("no_needle: expected %0d, got %0d", want.no_needle, out_data.no_needle);
          bad_results++;
        end
        if (out_data.calibration_error !== want.calibration_error) begin
          $error("calibration_error: expected %0d, got %0d", want.calibration_error,
                 out_data.calibration_error);
          bad_results++;
        end
      end
    end
  end

  initial begin : result_sink
    int span, chance, hold_cycles;
    span = 0;
    chance = 100;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        if (span == 0) begin
          span = $urandom_range(10, 80);
          case ($urandom_range(0, 2))
            0: chance = 100;
            1: chance = 50;
            default: chance = 20;
          endcase
        end
        span--;
        out_ready <= ($urandom_range(1, 100) <= chance);
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int          w, h, eh, scan, half, c1, c2, n, random_base;
    logic [31:0] v1, v2;
    bit          prev_pixel;

    plan.push_back(reg_step(REG_FRAME_WIDTH, 2));
    plan.push_back(reg_step(REG_FRAME_HEIGHT, 1));
    plan.push_back(reg_step(REG_SCAN_ROW, 0));
    plan.push_back(reg_step(REG_BAND_HALF, 0));
    plan.push_back(reg_step(REG_FIRST_COLUMN, 0));
    plan.push_back(reg_step(REG_FIRST_VALUE, 0));
    plan.push_back(reg_step(REG_SECOND_COLUMN, 4));
    plan.push_back(reg_step(REG_SECOND_VALUE, 1024));
    // empty band gives column 0 at level 255
    plan.push_back(pixel_step(8'd37, 1'b1));
    plan.push_back(pixel_want(8'd200, 1'b0, 0, 255, 0, 1'b0, 1'b0));
    plan.push_back(reg_step(REG_FRAME_HEIGHT, 3));
    plan.push_back(reg_step(REG_SCAN_ROW, 1));
    plan.push_back(reg_step(REG_BAND_HALF, 1));
    // every minimum zero: no needle
    plan.push_back(pixel_step(8'd0, 1'b1));
    repeat (4) plan.push_back(pixel_step(8'd0, 1'b0));
    plan.push_back(pixel_want(8'd0, 1'b0, -1, 0, -256, 1'b1, 1'b0));
    // frame start in mid frame
    plan.push_back(pixel_step(8'd255, 1'b1));
    plan.push_back(pixel_step(8'd255, 1'b0));
    plan.push_back(pixel_step(8'd1, 1'b1));
    plan.push_back(pixel_step(8'd255, 1'b0));
    plan.push_back(pixel_step(8'd200, 1'b0));
    plan.push_back(pixel_step(8'd254, 1'b0));
    plan.push_back(pixel_step(8'd0, 1'b0));
    plan.push_back(pixel_step(8'd0, 1'b0));
    // equal calibration columns, frame begins on the wrap alone
    plan.push_back(reg_step(REG_SECOND_COLUMN, 0));
    plan.push_back(pixel_step(8'd255, 1'b0));
    plan.push_back(pixel_step(8'd0, 1'b0));
    plan.push_back(pixel_step(8'd9, 1'b0));
    plan.push_back(pixel_step(8'd0, 1'b0));
    plan.push_back(pixel_step(8'd3, 1'b0));
    plan.push_back(pixel_want(8'd3, 1'b0, 0, 9, 0, 1'b0, 1'b1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_pixel = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_REG) begin
        if (prev_pixel) wait_idle();
        write_reg(plan[i].reg_index, plan[i].reg_value);
        prev_pixel = 1'b0;
      end else begin
        send_pixel(plan[i].px, plan[i].typed, plan[i].want);
        pace();
        prev_pixel = 1'b1;
      end
    end

    // extreme calibration values; writes every column minimum the random frames reach
    program_phase(8, 2, 0, 1, 0, 32'h0080_0000, 7, 32'h007f_ffff);
    stream_frames(1, 1'b0, 1'b0);
    // zero width and height: every pixel ends a frame
    program_phase(0, 0, 0, 0, 5, 32'h0000_1234, 9, 32'h00ff_0000);
    stream_frames(30, 1'b0, 1'b0);
    // receiver holds off while small frames keep coming
    program_phase(2, 2, 0, 1, 0, 32'h0000_0100, 1, 32'h0000_0200);
    hold_out = 1'b1;
    stream_frames(40, 1'b0, 1'b0);

    random_base = pixels_sent;
    while (pixels_sent - random_base < 670) begin
      w = $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) w = 0;
      h = $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) h = 0;
      eh = clamp_dim(h, MAX_HEIGHT);
      scan = $urandom_range(0, eh + 1);
      if ($urandom_range(0, 9) == 0) scan = 1023;
      half = $urandom_range(0, 4);
      if ($urandom_range(0, 9) == 0) half = 1023;
      c1 = $urandom_range(0, 15);
      c2 = $urandom_range(0, 15);
      if ($urandom_range(0, 7) == 0) c2 = c1;
      if ($urandom_range(0, 9) == 0) c1 = 1023;
      v1 = pick_value();
      v2 = pick_value();
      program_phase(w, h, scan, half, c1, v1, c2, v2);
      stream_frames($urandom_range(2, 6), $urandom_range(0, 3) == 0, 1'b1);
    end

    in_valid <= 1'b0;
    for (n = 0; n < 20000 && pending_readings.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_readings.size() != 0) begin
      $error("%0d expected results never arrived", pending_readings.size());
    end
    if (bad_results == 0 && pending_readings.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
